[rtl/dpm_pkg.sv]
package dpm_pkg;

    localparam int QBITS             = 30;
    localparam int LN_TABLE_BITS_DEF = 8;

    localparam int T_W   = 15;
    localparam int H_W   = 14;
    localparam int DEW_W = 15;

    localparam int TC_MIN  = -4549;
    localparam int TC_MAX  = 6549;
    localparam int H_MIN   = 50;
    localparam int DEW_MIN = -9000;
    localparam int DEW_MAX = 7000;

    // a = 17.62 and b = 243.12 scaled by 100; DEW_NUM = 100 * b * 100
    localparam int A_COEF  = 1762;
    localparam int B_COEF  = 24312;
    localparam int DEW_NUM = 2431200;

    // shift-subtract divide, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(num/den) in Q30 for den <= num < 2*den, 2*atanh((n-d)/(n+d)) series
    function automatic logic [63:0] ln_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] term;
        logic [63:0] sum;
        z    = udiv64((num - den) << QBITS, num + den);
        zz   = (z * z) >> QBITS;
        term = z;
        sum  = '0;
        for (int k = 0; k < 24; k++)
        begin
            sum  = sum + udiv64(term, 64'(2 * k + 1));
            term = (term * zz) >> QBITS;
        end
        return sum << 1;
    endfunction

    localparam logic [63:0] LN2_Q     = ln_ratio(64'd2, 64'd1);
    localparam logic [63:0] LN10000_Q = 64'd13 * LN2_Q + ln_ratio(64'd10000, 64'd8192);

endpackage

[rtl/dpm_div.sv]
module dpm_div
    #(
        parameter int D_W    = 25,
        parameter int Q_W    = 33,
        parameter int SPS    = 4,
        parameter int SIDE_W = 1
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              en,
        input  logic              in_valid,
        input  logic [D_W-1:0]    num,
        input  logic [D_W-1:0]    div,
        input  logic [SIDE_W-1:0] side_in,
        output logic              out_valid,
        output logic [Q_W-1:0]    quo,
        output logic [SIDE_W-1:0] side_out
    );

    // quo = floor(num * 2^Q_W / div), valid when num < div
    localparam int NSTG = (Q_W + SPS - 1) / SPS;

    logic              v_reg    [NSTG];
    logic [D_W-1:0]    r_reg    [NSTG];
    logic [D_W-1:0]    d_reg    [NSTG];
    logic [Q_W-1:0]    q_reg    [NSTG];
    logic [SIDE_W-1:0] s_reg    [NSTG];
    logic              v_next   [NSTG];
    logic [D_W-1:0]    r_next   [NSTG];
    logic [D_W-1:0]    d_next   [NSTG];
    logic [Q_W-1:0]    q_next   [NSTG];
    logic [SIDE_W-1:0] s_next   [NSTG];

    always_comb
    begin
        logic [D_W:0]   r2;
        logic [D_W-1:0] r;
        logic [D_W-1:0] d;
        logic [Q_W-1:0] q;
        r2 = '0;
        for (int stg = 0; stg < NSTG; stg++)
        begin
            if (stg == 0)
            begin
                v_next[stg] = in_valid;
                r           = num;
                d           = div;
                q           = '0;
                s_next[stg] = side_in;
            end
            else
            begin
                v_next[stg] = v_reg[stg-1];
                r           = r_reg[stg-1];
                d           = d_reg[stg-1];
                q           = q_reg[stg-1];
                s_next[stg] = s_reg[stg-1];
            end
            for (int j = 0; j < SPS; j++)
            begin
                if (stg * SPS + j < Q_W)
                begin
                    r2 = {r, 1'b0};
                    if (r2 >= {1'b0, d})
                    begin
                        r = D_W'(r2 - {1'b0, d});
                        q = {q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = r2[D_W-1:0];
                        q = {q[Q_W-2:0], 1'b0};
                    end
                end
            end
            r_next[stg] = r;
            d_next[stg] = d;
            q_next[stg] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int stg = 0; stg < NSTG; stg++)
            begin
                v_reg[stg] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int stg = 0; stg < NSTG; stg++)
            begin
                v_reg[stg] <= v_next[stg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int stg = 0; stg < NSTG; stg++)
            begin
                r_reg[stg] <= r_next[stg];
                d_reg[stg] <= d_next[stg];
                q_reg[stg] <= q_next[stg];
                s_reg[stg] <= s_next[stg];
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign quo       = q_reg[NSTG-1];
    assign side_out  = s_reg[NSTG-1];

endmodule

[rtl/dew_point_magnus.sv]
// Channel  Handshake            Payload
// input    in_valid / in_ready   temperature_centi, humidity_centi
// output   out_valid / out_ready dew_point_centi, result_valid
//
// One request per cycle while out_ready does not hold the output; each one passes input decode,
// 3 ln table stages, 9-stage a*T/(b+T) divider, 3 stages, 7-stage dew divider and the
// output register. The two restoring dividers set the depth.
// Reset clears only the stage valid bits; the ln table is constant.
// A held result stalls every stage at once; nothing is dropped or repeated.
module dew_point_magnus
    import dpm_pkg::*;
    #(
        parameter int LN_TABLE_BITS = LN_TABLE_BITS_DEF
    )
    (
        input  logic                    clk,
        input  logic                    rst_n,
        input  logic                    in_valid,
        output logic                    in_ready,
        input  logic signed [T_W-1:0]   temperature_centi,
        input  logic [H_W-1:0]          humidity_centi,
        output logic                    out_valid,
        input  logic                    out_ready,
        output logic signed [DEW_W-1:0] dew_point_centi,
        output logic                    result_valid
    );

    localparam int TSIZE  = (1 << LN_TABLE_BITS) + 1;
    localparam int IDX_W  = LN_TABLE_BITS + 1;
    localparam int REM_W  = QBITS - LN_TABLE_BITS;
    localparam int PROD_W = 32 + REM_W;
    localparam int M_W    = 25;
    localparam int A_W    = 36;
    localparam int ELN_W  = 35;
    localparam int NUM_W  = 58;
    localparam int DEN_W  = 42;
    localparam int Q2_W   = 14;
    localparam int DV_W   = DEN_W + Q2_W;
    localparam int Q1_W   = QBITS + 3;

    typedef logic [31:0] rom_t [TSIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TSIZE; i++)
        begin
            r[i] = 32'(ln_ratio(64'((1 << LN_TABLE_BITS) + i), 64'(1 << LN_TABLE_BITS)));
        end
        return r;
    endfunction

    localparam rom_t LN_ROM = build_rom();

    logic                    out_valid_reg;
    logic signed [DEW_W-1:0] dew_reg;
    logic                    rv_reg;

    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: range check, |T| and b+T scaling, normalize humidity
    logic [T_W-1:0]             tc_abs;
    logic signed [16:0]         tsum;
    logic [26:0]                d8_full;
    logic [3:0]                 e;
    logic [H_W-1:0]             hn;
    logic [QBITS-1:0]           frac30;
    logic                       ok;

    assign tc_abs  = temperature_centi[T_W-1] ? T_W'(~temperature_centi + 1'b1)
                                              : temperature_centi;
    assign tsum    = 17'(B_COEF) + 17'(temperature_centi);
    assign d8_full = 27'(tsum) * 27'd800;
    assign ok      = (temperature_centi >= T_W'(TC_MIN)) && (temperature_centi <= T_W'(TC_MAX))
                     && (humidity_centi >= H_W'(H_MIN));

    always_comb
    begin
        e = '0;
        for (int i = 0; i < H_W; i++)
        begin
            if (humidity_centi[i])
            begin
                e = 4'(i);
            end
        end
    end

    assign hn     = humidity_centi << (4'(H_W - 1) - e);
    assign frac30 = {hn[H_W-2:0], {(QBITS - H_W + 1){1'b0}}};

    logic                     s1_v_reg;
    logic                     s1_ok_reg;
    logic                     s1_neg_reg;
    logic [M_W-1:0]           s1_m_reg;
    logic [M_W-1:0]           s1_d8_reg;
    logic [3:0]               s1_e_reg;
    logic [LN_TABLE_BITS-1:0] s1_idx_reg;
    logic [REM_W-1:0]         s1_rem_reg;

    // stage 2: table read, e * ln2
    logic [31:0] lo;
    logic [31:0] hi;
    assign lo = LN_ROM[{1'b0, s1_idx_reg}];
    assign hi = LN_ROM[{1'b0, s1_idx_reg} + IDX_W'(1)];

    logic             s2_v_reg;
    logic             s2_ok_reg;
    logic             s2_neg_reg;
    logic [M_W-1:0]   s2_m_reg;
    logic [M_W-1:0]   s2_d8_reg;
    logic [31:0]      s2_lo_reg;
    logic [31:0]      s2_diff_reg;
    logic [REM_W-1:0] s2_rem_reg;
    logic [ELN_W-1:0] s2_eln_reg;

    // stage 3: interpolate
    logic [PROD_W-1:0] prod;
    assign prod = PROD_W'(s2_diff_reg) * PROD_W'(s2_rem_reg);

    logic             s3_v_reg;
    logic             s3_ok_reg;
    logic             s3_neg_reg;
    logic [M_W-1:0]   s3_m_reg;
    logic [M_W-1:0]   s3_d8_reg;
    logic [32:0]      s3_interp_reg;
    logic [ELN_W-1:0] s3_eln_reg;

    // stage 4: ln(RH/100)
    logic [A_W-1:0] lnv;
    assign lnv = A_W'(s3_eln_reg) + A_W'(s3_interp_reg) - A_W'(LN10000_Q);

    logic           s4_v_reg;
    logic           s4_ok_reg;
    logic           s4_neg_reg;
    logic [M_W-1:0] s4_m_reg;
    logic [M_W-1:0] s4_d8_reg;
    logic [A_W-1:0] s4_ln_reg;

    // a*T/(b+T) magnitude: floor(1762|tc| * 2^33 / (800 (24312+tc)))
    logic                  d1_v;
    logic [Q1_W-1:0]       d1_q;
    logic [A_W+1:0]        d1_side;

    dpm_div
        #(
            .D_W    (M_W),
            .Q_W    (Q1_W),
            .SPS    (4),
            .SIDE_W (A_W + 2)
        )
        u_div_frac
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s4_v_reg),
            .num       (s4_m_reg),
            .div       (s4_d8_reg),
            .side_in   ({s4_ok_reg, s4_neg_reg, s4_ln_reg}),
            .out_valid (d1_v),
            .quo       (d1_q),
            .side_out  (d1_side)
        );

    // stage 5: alpha
    logic [A_W-1:0] fracv;
    assign fracv = d1_side[A_W] ? A_W'(-A_W'(d1_q)) : A_W'(d1_q);

    logic           s5_v_reg;
    logic           s5_ok_reg;
    logic [A_W-1:0] s5_alpha_reg;

    // stage 6: numerator magnitude and denominator
    logic [A_W-1:0] a_abs;
    logic [43:0]    den_full;
    assign a_abs    = s5_alpha_reg[A_W-1] ? A_W'(-s5_alpha_reg) : s5_alpha_reg;
    assign den_full = (44'(A_COEF) << QBITS)
                      - 44'({{(44 - A_W){s5_alpha_reg[A_W-1]}}, s5_alpha_reg}) * 44'd100;

    logic             s6_v_reg;
    logic             s6_ok_reg;
    logic             s6_neg_reg;
    logic [NUM_W-1:0] s6_num_reg;
    logic [DEN_W-1:0] s6_den_reg;

    // stage 7: add half divisor for round to nearest
    logic            s7_v_reg;
    logic            s7_ok_reg;
    logic            s7_neg_reg;
    logic [DV_W-1:0] s7_n_reg;
    logic [DV_W-1:0] s7_dv_reg;

    logic            d2_v;
    logic [Q2_W-1:0] d2_q;
    logic [1:0]      d2_side;

    dpm_div
        #(
            .D_W    (DV_W),
            .Q_W    (Q2_W),
            .SPS    (2),
            .SIDE_W (2)
        )
        u_div_dew
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s7_v_reg),
            .num       (s7_n_reg),
            .div       (s7_dv_reg),
            .side_in   ({s7_ok_reg, s7_neg_reg}),
            .out_valid (d2_v),
            .quo       (d2_q),
            .side_out  (d2_side)
        );

    // output: sign, saturate, invalid forces zero
    logic signed [DEW_W-1:0] dew;
    always_comb
    begin
        if (d2_side[0])
        begin
            dew = (d2_q > Q2_W'(-DEW_MIN)) ? DEW_W'(DEW_MIN) : -$signed({1'b0, d2_q});
        end
        else
        begin
            dew = (d2_q > Q2_W'(DEW_MAX)) ? DEW_W'(DEW_MAX) : $signed({1'b0, d2_q});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= d1_v;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            out_valid_reg <= d2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg     <= ok;
            s1_neg_reg    <= temperature_centi[T_W-1];
            s1_m_reg      <= M_W'(tc_abs) * M_W'(A_COEF);
            s1_d8_reg     <= d8_full[M_W-1:0];
            s1_e_reg      <= e;
            s1_idx_reg    <= frac30[QBITS-1 -: LN_TABLE_BITS];
            s1_rem_reg    <= frac30[REM_W-1:0];

            s2_ok_reg     <= s1_ok_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_m_reg      <= s1_m_reg;
            s2_d8_reg     <= s1_d8_reg;
            s2_lo_reg     <= lo;
            s2_diff_reg   <= hi - lo;
            s2_rem_reg    <= s1_rem_reg;
            s2_eln_reg    <= ELN_W'(s1_e_reg) * ELN_W'(LN2_Q);

            s3_ok_reg     <= s2_ok_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_m_reg      <= s2_m_reg;
            s3_d8_reg     <= s2_d8_reg;
            s3_interp_reg <= 33'(s2_lo_reg) + 33'(prod >> REM_W);
            s3_eln_reg    <= s2_eln_reg;

            s4_ok_reg     <= s3_ok_reg;
            s4_neg_reg    <= s3_neg_reg;
            s4_m_reg      <= s3_m_reg;
            s4_d8_reg     <= s3_d8_reg;
            s4_ln_reg     <= lnv;

            s5_ok_reg     <= d1_side[A_W+1];
            s5_alpha_reg  <= d1_side[A_W-1:0] + fracv;

            s6_ok_reg     <= s5_ok_reg;
            s6_neg_reg    <= s5_alpha_reg[A_W-1];
            s6_num_reg    <= NUM_W'(a_abs) * NUM_W'(DEW_NUM);
            s6_den_reg    <= den_full[DEN_W-1:0];

            s7_ok_reg     <= s6_ok_reg;
            s7_neg_reg    <= s6_neg_reg;
            s7_n_reg      <= s6_num_reg[DV_W-1:0] + DV_W'(s6_den_reg >> 1);
            s7_dv_reg     <= {s6_den_reg, {Q2_W{1'b0}}};

            dew_reg       <= d2_side[1] ? dew : '0;
            rv_reg        <= d2_side[1];
        end
    end

    assign out_valid       = out_valid_reg;
    assign dew_point_centi = dew_reg;
    assign result_valid    = rv_reg;

endmodule
